/* rtl/core/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked assertion that stays live through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/mmft_pkg.sv */
package mmft_pkg;

  localparam int unsigned VALUE_W     = 10;
  localparam int unsigned MAX_COUNT_W = 11;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_CNT  = 6'b000100,
    S_POP1 = 6'b001000,
    S_POP2 = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

endpackage

/* rtl/core/mmft_ram.sv */
module mmft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/multiset_max_frequency_tracker.sv */
// Multiset maximum-multiplicity tracker.
// Input channel s_axis: tuser is the operation (0 add one copy, 1 remove one
// copy), tdata[9:0] the value. Output channel m_axis: one transfer per input
// item, tdata[10:0] the largest multiplicity after that item, tuser the error
// flag (remove of an absent value, add at capacity, value out of range; the
// state is then left as it was).
// Each item is a read-modify-write over two single-port-read memories, the
// per-value count table and the per-multiplicity population table, driven by
// a small sequencer: one count read, then two population read/write steps.
// A refused item skips the population steps, and a value out of range skips
// the count read as well. A new item is taken the cycle after the result
// enters the output register, so the block takes no item before it is through
// with the last one; the population table port sets this pace.
// After reset both tables are zeroed by a clearing pass that walks
// max(NUM_VALUES, MAX_ITEMS+1) addresses (1025 by default) with s_axis_tready_o
// low. The result sits in an output register; while the receiver stalls a
// finished item waits there and the next item runs up to its own result.
module multiset_max_frequency_tracker #(
  parameter int unsigned NUM_VALUES = 1024,
  parameter int unsigned MAX_ITEMS  = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [mmft_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // [9:0] value
  input  logic                                 s_axis_tuser_i,  // [0] operation
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [mmft_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,  // [10:0] max_count
  output logic                                 m_axis_tuser_o   // [0] error
);

  localparam int unsigned VW    = $clog2(NUM_VALUES);
  localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned PW    = $clog2(NUM_VALUES + 1);
  localparam int unsigned CLR_N = (NUM_VALUES > MAX_ITEMS + 1) ? NUM_VALUES : MAX_ITEMS + 1;
  localparam int unsigned CLRW  = $clog2(CLR_N);

  mmft_pkg::state_e state_q, state_d;
  logic             op_q, op_d;
  logic [VW-1:0]    val_q, val_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    max_q, max_d;
  logic             err_q, err_d;
  logic [CLRW-1:0]  clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic [CW-1:0]    out_max_q, out_max_d;
  logic             out_err_q, out_err_d;

  logic          cnt_we;
  logic [VW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;
  logic          pop_we;
  logic [CW-1:0] pop_waddr, pop_raddr;
  logic [PW-1:0] pop_wdata, pop_rdata;

  logic in_xfer, out_free, in_range, is_add;
  logic [CW-1:0] nxt_cnt;

  mmft_ram #(.WIDTH(CW), .DEPTH(NUM_VALUES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  mmft_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS + 1)) u_pop_ram (
    .clk_i   (clk_i),
    .we_i    (pop_we),
    .waddr_i (pop_waddr),
    .wdata_i (pop_wdata),
    .raddr_i (pop_raddr),
    .rdata_o (pop_rdata)
  );

  assign s_axis_tready_o = (state_q == mmft_pkg::S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_range        = 32'(s_axis_tdata_i[mmft_pkg::VALUE_W-1:0]) < 32'(NUM_VALUES);
  assign is_add          = (op_q == mmft_pkg::OP_ADD);
  // neighbor multiplicity touched by the second population step
  assign nxt_cnt         = is_add ? cnt_q + CW'(1) : cnt_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    max_d       = max_q;
    err_d       = err_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_max_d   = out_max_q;
    out_err_d   = out_err_q;
    cnt_we      = 1'b0;
    cnt_waddr   = val_q;
    cnt_wdata   = cnt_rdata;
    cnt_raddr   = VW'(s_axis_tdata_i[mmft_pkg::VALUE_W-1:0]);
    pop_we      = 1'b0;
    pop_waddr   = cnt_q;
    pop_wdata   = pop_rdata;
    pop_raddr   = cnt_q;

    unique case (state_q)
      mmft_pkg::S_CLR: begin
        cnt_we    = 32'(clr_q) < 32'(NUM_VALUES);
        cnt_waddr = VW'(clr_q);
        cnt_wdata = '0;
        pop_we    = 32'(clr_q) < 32'(MAX_ITEMS + 1);
        pop_waddr = CW'(clr_q);
        pop_wdata = '0;
        clr_d     = clr_q + CLRW'(1);
        if (clr_q == CLRW'(CLR_N - 1)) begin
          state_d = mmft_pkg::S_IDLE;
        end
      end
      mmft_pkg::S_IDLE: begin
        if (in_xfer) begin
          op_d  = s_axis_tuser_i;
          val_d = VW'(s_axis_tdata_i[mmft_pkg::VALUE_W-1:0]);
          err_d = !in_range;
          state_d = in_range ? mmft_pkg::S_CNT : mmft_pkg::S_DONE;
        end
      end
      mmft_pkg::S_CNT: begin
        cnt_d = cnt_rdata;
        if (is_add ? (cnt_rdata == CW'(MAX_ITEMS)) : (cnt_rdata == '0)) begin
          err_d   = 1'b1;
          state_d = mmft_pkg::S_DONE;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = is_add ? cnt_rdata + CW'(1) : cnt_rdata - CW'(1);
          pop_raddr = cnt_rdata;
          state_d   = mmft_pkg::S_POP1;
        end
      end
      mmft_pkg::S_POP1: begin
        // population of the old multiplicity drops; zero is never kept
        pop_we    = !is_add || (cnt_q != '0);
        pop_waddr = cnt_q;
        pop_wdata = pop_rdata - PW'(1);
        pop_raddr = nxt_cnt;
        if (max_q == cnt_q) begin
          if (is_add) begin
            max_d = cnt_q + CW'(1);
          end else if (pop_rdata == PW'(1)) begin
            max_d = max_q - CW'(1);
          end
        end
        state_d = mmft_pkg::S_POP2;
      end
      mmft_pkg::S_POP2: begin
        pop_we    = is_add || (nxt_cnt != '0);
        pop_waddr = nxt_cnt;
        pop_wdata = pop_rdata + PW'(1);
        state_d   = mmft_pkg::S_DONE;
      end
      mmft_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_max_d   = max_q;
          out_err_d   = err_q;
          state_d     = mmft_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mmft_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmft_pkg::S_CLR;
      clr_q       <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    cnt_q     <= cnt_d;
    err_q     <= err_d;
    out_max_q <= out_max_d;
    out_err_q <= out_err_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = mmft_pkg::OUT_TDATA_W'(mmft_pkg::MAX_COUNT_W'(out_max_q));
  assign m_axis_tuser_o  = out_err_q;

endmodule

/* rtl/core/mmft_checker.sv */
`include "assert_macros.svh"

module mmft_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [mmft_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                             s_axis_tuser_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [mmft_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);

  // a stalled result keeps its payload
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  // one item in flight: no input transfer right after another
  `ASSERT_CLK(a_one_item, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "input taken while item in flight")

  // the tables are being cleared just after reset
  `ASSERT_CLK(a_clear_pass, clk_i, rst_ni, !$past(rst_ni) |-> !s_axis_tready_o && !m_axis_tvalid_o, "input taken during clearing pass")

  // padding above the 11-bit max_count field of a valid result stays zero
  `ASSERT_CLK(a_max_range, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[15:11] == 5'd0, "max_count padding not zero")

endmodule

bind multiset_max_frequency_tracker mmft_checker u_mmft_checker (.*);

/* tb/tb_multiset_max_frequency_tracker.sv */
`timescale 1ns / 1ps

module tb_multiset_max_frequency_tracker;

  localparam int unsigned NUM_VALUES = 1024;
  localparam int unsigned MAX_ITEMS  = 1024;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned VALUE_W     = mmft_pkg::VALUE_W;
  localparam int unsigned MAX_COUNT_W = mmft_pkg::MAX_COUNT_W;
  localparam int unsigned IN_TDATA_W  = mmft_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = mmft_pkg::OUT_TDATA_W;

  typedef struct packed {
    logic [MAX_COUNT_W-1:0] max_count;
    logic                   error;
  } mode_result_t;

  // predicts the reported peak multiplicity and keeps the results still owed
  class multiset_scoreboard;
    int unsigned  count_of [NUM_VALUES];
    int unsigned  values_at [MAX_ITEMS+1];
    int unsigned  peak;
    mode_result_t expected_maxima [$];
    int           failures;

    function new();
      foreach (count_of[i]) count_of[i] = 0;
      foreach (values_at[i]) values_at[i] = 0;
      peak = 0;
      failures = 0;
    endfunction

    function void note_item(mmft_pkg::op_e op, logic [VALUE_W-1:0] v);
      mode_result_t r;
      int unsigned  f;
      f = count_of[v];
      r.error = 1'b0;
      if (op == mmft_pkg::OP_ADD) begin
        if (f >= MAX_ITEMS) begin
          r.error = 1'b1;
        end else begin
          count_of[v] = f + 1;
          if (f >= 1) values_at[f]--;
          values_at[f+1]++;
          if (peak == f) peak = f + 1;
        end
      end else begin
        if (f == 0) begin
          r.error = 1'b1;
        end else begin
          count_of[v] = f - 1;
          values_at[f]--;
          if (f > 1) values_at[f-1]++;
          // only one value moves, so the peak drops by at most one
          if (peak >= 1 && values_at[peak] == 0) peak--;
        end
      end
      r.max_count = peak[MAX_COUNT_W-1:0];
      expected_maxima.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
      mode_result_t e;
      if (expected_maxima.size() == 0) begin
        $error("unexpected result transfer: max_count %0d error %0d",
               tdata[MAX_COUNT_W-1:0], tuser);
        failures++;
        return;
      end
      e = expected_maxima.pop_front();
      if (tdata[MAX_COUNT_W-1:0] !== e.max_count) begin
        $error("max_count: expected %0d, got %0d", e.max_count, tdata[MAX_COUNT_W-1:0]);
        failures++;
      end
      if (tuser !== e.error) begin
        $error("error: expected %0d, got %0d", e.error, tuser);
        failures++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  multiset_scoreboard sb = new();
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          quiet = 1'b0;
  int unsigned cycles = 0;

  multiset_max_frequency_tracker #(
    .NUM_VALUES(NUM_VALUES),
    .MAX_ITEMS (MAX_ITEMS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_multiset_max_frequency_tracker NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (quiet || stall_pct == 0) begin
        m_axis_tready_i = 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input mmft_pkg::op_e op, input logic [VALUE_W-1:0] v);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {{(IN_TDATA_W-VALUE_W){1'b0}}, v};
    s_axis_tuser_i  = op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(op, v);
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    mmft_pkg::op_e op;
    op = ($urandom_range(0, 1) == 0) ? mmft_pkg::OP_ADD : mmft_pkg::OP_REMOVE;
    send_item(op, VALUE_W'($urandom_range(0, NUM_VALUES-1)));
  endtask

  // most items hit a small pool so multiplicities build up and ties occur
  task automatic run_mix(input int n, input int unsigned add_pct);
    logic [VALUE_W-1:0] pool [6];
    mmft_pkg::op_e      op;
    logic [VALUE_W-1:0] v;
    foreach (pool[i]) pool[i] = VALUE_W'($urandom_range(0, NUM_VALUES-1));
    if ($urandom_range(0, 1) == 0) pool[0] = '0;
    else pool[0] = '1;
    repeat (n) begin
      op = ($urandom_range(0, 99) < add_pct) ? mmft_pkg::OP_ADD : mmft_pkg::OP_REMOVE;
      if ($urandom_range(0, 99) < 80) v = pool[$urandom_range(0, 5)];
      else v = VALUE_W'($urandom_range(0, NUM_VALUES-1));
      send_item(op, v);
    end
  endtask

  // drive one value up to capacity, then push against the ceiling
  task automatic climb_to_capacity();
    logic [VALUE_W-1:0] v;
    v = VALUE_W'($urandom_range(0, NUM_VALUES-1));
    while (sb.count_of[v] < MAX_ITEMS) begin
      if ($urandom_range(0, 99) < 92) send_item(mmft_pkg::OP_ADD, v);
      else send_random_item();
    end
    send_item(mmft_pkg::OP_ADD, v);
    send_item(mmft_pkg::OP_ADD, v);
    send_item(mmft_pkg::OP_REMOVE, v);
    send_item(mmft_pkg::OP_ADD, v);
    send_item(mmft_pkg::OP_ADD, v);
  endtask

  task automatic run_directed();
    send_item(mmft_pkg::OP_REMOVE, 10'd0);     // remove from an empty set
    send_item(mmft_pkg::OP_ADD, 10'd0);
    send_item(mmft_pkg::OP_ADD, 10'd1023);
    send_item(mmft_pkg::OP_ADD, 10'd0);
    send_item(mmft_pkg::OP_REMOVE, 10'd1023);
    send_item(mmft_pkg::OP_REMOVE, 10'd1023);  // absent again
    send_item(mmft_pkg::OP_ADD, 10'd1023);
    send_item(mmft_pkg::OP_ADD, 10'd1023);     // tie at the peak
    send_item(mmft_pkg::OP_REMOVE, 10'd0);     // peak held by the other value
    send_item(mmft_pkg::OP_REMOVE, 10'd1023);  // last value at the peak leaves
    send_item(mmft_pkg::OP_REMOVE, 10'd0);
    send_item(mmft_pkg::OP_REMOVE, 10'd1023);
    send_item(mmft_pkg::OP_REMOVE, 10'd1023);
    send_item(mmft_pkg::OP_ADD, 10'h2AA);
    send_item(mmft_pkg::OP_ADD, 10'h155);
    send_item(mmft_pkg::OP_ADD, 10'h2AA);
    send_item(mmft_pkg::OP_ADD, 10'h2AA);
    send_item(mmft_pkg::OP_REMOVE, 10'h155);
    send_item(mmft_pkg::OP_REMOVE, 10'h155);
    send_item(mmft_pkg::OP_REMOVE, 10'h2AA);
    send_item(mmft_pkg::OP_REMOVE, 10'h2AA);
    send_item(mmft_pkg::OP_REMOVE, 10'h2AA);
  endtask

  initial begin
    int unsigned pct_choice [4];
    pct_choice[0] = 0;
    pct_choice[1] = 10;
    pct_choice[2] = 30;
    pct_choice[3] = 60;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();

    for (int seg = 0; seg < 8; seg++) begin
      gap_pct   = pct_choice[$urandom_range(0, 3)];
      stall_pct = pct_choice[$urandom_range(0, 3)];
      run_mix(15, (seg % 3 == 2) ? 30 : 65);
    end

    gap_pct   = 10;
    stall_pct = 10;
    climb_to_capacity();

    for (int seg = 0; seg < 5; seg++) begin
      gap_pct   = pct_choice[$urandom_range(0, 3)];
      stall_pct = pct_choice[$urandom_range(0, 3)];
      run_mix(15, (seg % 2 == 0) ? 40 : 60);
    end

    quiet = 1'b1;
    run_mix(150, 50);
    s_axis_tvalid_i = 1'b0;

    while (sb.expected_maxima.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.failures == 0 && sb.expected_maxima.size() == 0) begin
      $display("tb_multiset_max_frequency_tracker OK");
    end else begin
      $display("tb_multiset_max_frequency_tracker NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mmft_pkg.sv
rtl/core/mmft_ram.sv
rtl/core/multiset_max_frequency_tracker.sv
rtl/core/mmft_checker.sv
tb/tb_multiset_max_frequency_tracker.sv
